// ===== hdl/pixel_peak_select_score_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for pixel_peak_select_score
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_PEAK_SELECT_SCORE_ASSERT_SVH
`define PIXEL_PEAK_SELECT_SCORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PPSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel_peak_select_score: same-cycle check failed");

// next-cycle implication
`define PPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_peak_select_score: next-cycle check failed");

`else

`define PPSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ppss_pkg.sv =====
// ----------------------------------------------------------------------------
// ppss_pkg
// Widths, register codes, sorting network layout and the pixel job record.
// ----------------------------------------------------------------------------
package ppss_pkg;

	localparam int MAX_VALUES   = 256;
	localparam int SLOT_COUNT   = 8;
	localparam int SLOTS_NARROW = 4;
	localparam int SLOT_W       = $clog2(SLOT_COUNT);
	localparam int POS_W        = $clog2(MAX_VALUES + 1);
	localparam int COUNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int VALUE_W      = 16;
	localparam int SCORE_W      = 22;
	localparam int KEY_W        = VALUE_W + 1 + SLOT_W;
	localparam int SORT_LAYERS  = 6;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 22;

	localparam logic signed [VALUE_W-1:0] EIGHT_SLOT_LIMIT       = 16'sd6554;
	localparam logic signed [VALUE_W-1:0] SAMPLE_THRESHOLD_RESET = 16'sd6554;
	localparam logic signed [SCORE_W-1:0] SCORE_THRESHOLD_RESET  = '0;

	// below any sample value: parks unused slots at the bottom of the sort
	localparam logic signed [VALUE_W:0] EMPTY_RANK_VALUE = {1'b1, {VALUE_W{1'b0}}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_THRESHOLD,
		REG_SCORE_THRESHOLD
	} cfg_reg_t;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	// compare partner of each lane per layer, 19 compare-exchange cells
	localparam slot_idx_t SORT_PARTNER [SORT_LAYERS][SLOT_COUNT] = '{
		'{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6},
		'{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd7},
		'{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7},
		'{3'd0, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7}
	};

	typedef struct packed {
		logic [SLOT_COUNT-1:0][KEY_W-1:0] key;
		logic [SLOT_COUNT-1:0][POS_W-1:0] pos;
		logic                             wide;
		logic                             found;
	} ppss_job_t;

endpackage

// ===== hdl/ppss_if.sv =====
// ----------------------------------------------------------------------------
// ppss stream interfaces
// Sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppss_sample_if import ppss_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sample_value;
	logic                      last_of_pixel;

	modport source (output valid, output sample_value, output last_of_pixel, input ready);
	modport sink (input valid, input sample_value, input last_of_pixel, output ready);
endinterface

interface ppss_result_if import ppss_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [POS_W-1:0]          best_index;
	logic signed [SCORE_W-1:0] pixel_score;
	logic                      good;

	modport source (output valid, output found, output best_index, output pixel_score,
		output good, input ready);
	modport sink (input valid, input found, input best_index, input pixel_score,
		input good, output ready);
endinterface

// ===== hdl/pixel_peak_select_score.sv =====
// ----------------------------------------------------------------------------
// pixel_peak_select_score
// Per-pixel peak selection over a stream of Q1.15 scores, with ranked score.
// ----------------------------------------------------------------------------
// Takes one sample per clock with no gaps needed between pixels. Kept samples
// go into four or eight slots as they arrive; the final sample of a pixel
// launches a job into an eleven-stage pipeline (snapshot, six layers of a
// sorting network, weighting, two adder levels, sum and compare), and the
// pixel's result is presented from the last of these stages. The sample
// side stalls only when that pipeline is full.
// ----------------------------------------------------------------------------
`include "pixel_peak_select_score_assert.svh"

module pixel_peak_select_score import ppss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	ppss_sample_if.sink            samples,
	ppss_result_if.source          results
);

	logic signed [VALUE_W-1:0] sample_threshold_q;
	logic signed [SCORE_W-1:0] score_threshold_q;

	logic signed [VALUE_W-1:0] slot_value_q [SLOT_COUNT];
	logic [POS_W-1:0]          slot_pos_q [SLOT_COUNT];
	logic [COUNT_W-1:0]        kept_count_q;
	logic [POS_W-1:0]          sample_position_q;

	logic                      sample_xfer;
	logic [POS_W:0]            pos_next;
	logic [POS_W-1:0]          pos_sat;
	logic                      wide;
	logic [COUNT_W-1:0]        slots_used;
	logic                      keep;
	logic [SLOT_W-1:0]         slot_idx;
	logic [COUNT_W-1:0]        kept_next;

	ppss_job_t                 job;
	logic                      job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_threshold_q <= SAMPLE_THRESHOLD_RESET;
			score_threshold_q  <= SCORE_THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_THRESHOLD: sample_threshold_q <= signed'(cfg_wdata[VALUE_W-1:0]);
				REG_SCORE_THRESHOLD:  score_threshold_q  <= signed'(cfg_wdata[SCORE_W-1:0]);
				default: ;
			endcase
		end
	end

	assign sample_xfer = samples.valid && samples.ready;
	assign pos_next    = {1'b0, sample_position_q} + (POS_W+1)'(1);
	assign pos_sat     = (pos_next > (POS_W+1)'(MAX_VALUES)) ? POS_W'(MAX_VALUES)
		: pos_next[POS_W-1:0];
	assign wide        = sample_threshold_q < EIGHT_SLOT_LIMIT;
	assign slots_used  = wide ? COUNT_W'(SLOT_COUNT) : COUNT_W'(SLOTS_NARROW);
	assign keep        = (pos_next <= (POS_W+1)'(MAX_VALUES))
		&& (samples.sample_value > sample_threshold_q)
		&& (kept_count_q < slots_used);
	assign slot_idx    = kept_count_q[SLOT_W-1:0];
	assign kept_next   = kept_count_q + COUNT_W'(keep);

	// snapshot of the slots as they stand after this sample
	always_comb begin
		logic signed [VALUE_W-1:0] v;
		logic [POS_W-1:0]          p;
		logic                      used;
		logic signed [VALUE_W:0]   rank_value;
		job.found = 1'b0;
		job.wide  = wide;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (keep && slot_idx == SLOT_W'(i)) begin
				v = samples.sample_value;
				p = pos_next[POS_W-1:0];
			end else begin
				v = slot_value_q[i];
				p = slot_pos_q[i];
			end
			used = COUNT_W'(i) < kept_next;
			if (!used) begin
				v = '0;
				p = '0;
			end
			if (i == 0) begin
				job.found = v > 0;
			end
			if (wide || i < SLOTS_NARROW) begin
				rank_value = (VALUE_W+1)'(v);
			end else begin
				rank_value = EMPTY_RANK_VALUE;
			end
			job.key[i] = {rank_value, SLOT_W'(SLOT_COUNT - 1 - i)};
			job.pos[i] = p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q      <= '0;
			sample_position_q <= '0;
		end else if (sample_xfer) begin
			if (samples.last_of_pixel) begin
				kept_count_q      <= '0;
				sample_position_q <= '0;
			end else begin
				kept_count_q      <= kept_next;
				sample_position_q <= pos_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer && keep) begin
			slot_value_q[slot_idx] <= samples.sample_value;
			slot_pos_q[slot_idx]   <= pos_next[POS_W-1:0];
		end
	end

	assign samples.ready = job_ready;

	ppss_rank u_rank (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (samples.valid && samples.last_of_pixel),
		.job_ready       (job_ready),
		.job             (job),
		.score_threshold (score_threshold_q),
		.results         (results)
	);

	`PPSS_ASSERT_SAME(a_kept_bound, clk, arst_n, 1'b1, kept_count_q <= COUNT_W'(SLOT_COUNT))
	`PPSS_ASSERT_NEXT(a_pixel_clear, clk, arst_n, sample_xfer && samples.last_of_pixel, (kept_count_q == '0) && (sample_position_q == '0))
	`PPSS_ASSERT_SAME(a_not_found_zero, clk, arst_n, results.valid && !results.found, (results.best_index == '0) && (results.pixel_score == '0) && !results.good)
	`PPSS_ASSERT_SAME(a_good_found, clk, arst_n, results.valid && results.good, results.found)

endmodule

// ===== hdl/ppss_rank.sv =====
// ----------------------------------------------------------------------------
// ppss_rank
// Pipelined descending sort of the slot values, rank-weighted sum and
// threshold compare, ending in the result register.
// ----------------------------------------------------------------------------
module ppss_rank import ppss_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  ppss_job_t                 job,
	input  logic signed [SCORE_W-1:0] score_threshold,
	ppss_result_if.source             results
);

	localparam int PROD_STAGE = SORT_LAYERS + 1;
	localparam int SUM4_STAGE = SORT_LAYERS + 2;
	localparam int SUM2_STAGE = SORT_LAYERS + 3;
	localparam int OUT_STAGE  = SORT_LAYERS + 4;
	localparam int STAGES     = SORT_LAYERS + 5;

	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] take;

	logic [SLOT_COUNT-1:0][KEY_W-1:0] key_s [SORT_LAYERS+1];
	logic [SLOT_COUNT-1:0][POS_W-1:0] pos_s [SORT_LAYERS+1];
	logic                             wide_s [SORT_LAYERS+1];
	logic                             found_s [SORT_LAYERS+1];

	logic [SLOT_COUNT-1:0][KEY_W-1:0] key_n [SORT_LAYERS];
	logic [SLOT_COUNT-1:0][POS_W-1:0] pos_n [SORT_LAYERS];

	logic signed [SCORE_W-1:0] prod_n [SLOT_COUNT];
	logic signed [SCORE_W-1:0] prod_s8 [SLOT_COUNT];
	logic [POS_W-1:0]          best_s8;
	logic                      found_s8;

	logic signed [SCORE_W-1:0] sum_s9 [SLOT_COUNT/2];
	logic [POS_W-1:0]          best_s9;
	logic                      found_s9;

	logic signed [SCORE_W-1:0] sum_s10 [SLOT_COUNT/4];
	logic [POS_W-1:0]          best_s10;
	logic                      found_s10;

	logic signed [SCORE_W-1:0] score_n;
	logic                      good_n;

	logic                      found_s11;
	logic [POS_W-1:0]          best_s11;
	logic signed [SCORE_W-1:0] score_s11;
	logic                      good_s11;

	function automatic logic [COUNT_W-1:0] rank_weight(input logic wide, input int rank);
		logic [COUNT_W-1:0] w;
		if (wide) begin
			w = COUNT_W'(SLOT_COUNT - rank);
		end else if (rank < SLOTS_NARROW) begin
			w = COUNT_W'(SLOTS_NARROW - rank);
		end else begin
			w = '0;
		end
		return w;
	endfunction

	// a stage takes new data when empty or when its contents move on
	always_comb begin
		take[STAGES-1] = !valid_q[STAGES-1] || results.ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			take[i] = !valid_q[i] || take[i+1];
		end
	end

	assign job_ready = take[0];

	// compare-exchange layers, larger key towards lane zero
	always_comb begin
		int   p;
		logic own_wins;
		for (int l = 0; l < SORT_LAYERS; l++) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				p = int'(SORT_PARTNER[l][i]);
				own_wins = $signed(key_s[l][i]) > $signed(key_s[l][p]);
				if (p == i || ((i < p) == own_wins)) begin
					key_n[l][i] = key_s[l][i];
					pos_n[l][i] = pos_s[l][i];
				end else begin
					key_n[l][i] = key_s[l][p];
					pos_n[l][i] = pos_s[l][p];
				end
			end
		end
	end

	always_comb begin
		logic signed [VALUE_W:0]   value;
		logic signed [SCORE_W-1:0] value_ext;
		logic signed [SCORE_W-1:0] weight_ext;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			value      = signed'(key_s[SORT_LAYERS][i][KEY_W-1:SLOT_W]);
			value_ext  = SCORE_W'(value);
			weight_ext = signed'(SCORE_W'(rank_weight(wide_s[SORT_LAYERS], i)));
			prod_n[i]  = value_ext * weight_ext;
		end
	end

	assign score_n = sum_s10[0] + sum_s10[1];
	assign good_n  = score_n >= score_threshold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (take[0]) begin
				valid_q[0] <= job_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (take[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take[0]) begin
			key_s[0]   <= job.key;
			pos_s[0]   <= job.pos;
			wide_s[0]  <= job.wide;
			found_s[0] <= job.found;
		end
		for (int l = 0; l < SORT_LAYERS; l++) begin
			if (take[l+1]) begin
				key_s[l+1]   <= key_n[l];
				pos_s[l+1]   <= pos_n[l];
				wide_s[l+1]  <= wide_s[l];
				found_s[l+1] <= found_s[l];
			end
		end
		if (take[PROD_STAGE]) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				prod_s8[i] <= prod_n[i];
			end
			best_s8  <= pos_s[SORT_LAYERS][0];
			found_s8 <= found_s[SORT_LAYERS];
		end
		if (take[SUM4_STAGE]) begin
			for (int j = 0; j < SLOT_COUNT / 2; j++) begin
				sum_s9[j] <= prod_s8[2*j] + prod_s8[2*j+1];
			end
			best_s9  <= best_s8;
			found_s9 <= found_s8;
		end
		if (take[SUM2_STAGE]) begin
			for (int j = 0; j < SLOT_COUNT / 4; j++) begin
				sum_s10[j] <= sum_s9[2*j] + sum_s9[2*j+1];
			end
			best_s10  <= best_s9;
			found_s10 <= found_s9;
		end
		if (take[OUT_STAGE]) begin
			found_s11 <= found_s10;
			if (found_s10) begin
				best_s11  <= best_s10;
				score_s11 <= score_n;
				good_s11  <= good_n;
			end else begin
				best_s11  <= '0;
				score_s11 <= '0;
				good_s11  <= 1'b0;
			end
		end
	end

	assign results.valid       = valid_q[OUT_STAGE];
	assign results.found       = found_s11;
	assign results.best_index  = best_s11;
	assign results.pixel_score = score_s11;
	assign results.good        = good_s11;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pixel_peak_select_score. Streams directed and random
// pixels through the sample channel with random gaps and result-side stalls,
// predicts each pixel's found flag, best index, ranked score and good flag,
// and compares every result transfer in order. Register settings change
// between phases while the pipeline is empty, sometimes in the middle of a
// pixel.
// ----------------------------------------------------------------------------
module tb_top;
	import ppss_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_ITEMS    = 95;
	localparam int SCORE_MAX      = 1179612;
	localparam int SCORE_MIN      = -1179648;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} sample_item_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   best_index;
		logic [SCORE_W-1:0] pixel_score;
		logic               good;
	} pixel_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	cfg_reg_t               cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	ppss_sample_if sample_bus ();
	ppss_result_if result_bus ();

	pixel_peak_select_score u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_bus),
		.results   (result_bus)
	);

	sample_item_t  sample_queue [$];
	pixel_result_t pending_scores [$];

	logic sample_xfer = 1'b0;
	logic result_xfer = 1'b0;
	int   send_gap = 0;
	int   ready_hold = 0;
	int   idle_cycles = 0;
	int   mismatch_count = 0;
	int   queued_total = 0;
	int   stretch_left [2];
	bit   quiet [2];

	// predictor copy of registers and pixel state
	logic signed [VALUE_W-1:0] keep_thr;
	logic signed [SCORE_W-1:0] good_thr;
	logic signed [VALUE_W-1:0] slot_val [SLOT_COUNT];
	logic [POS_W-1:0]          slot_pos [SLOT_COUNT];
	int                        kept_count;
	int                        seen_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_pixel_slots();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_val[i] = '0;
			slot_pos[i] = '0;
		end
		kept_count = 0;
		seen_count = 0;
	endfunction

	function automatic bit rank_pixel_sample(input logic signed [VALUE_W-1:0] v,
		input logic last, output pixel_result_t res);
		int k_use;
		int pos;
		int maxv;
		int score;
		int t;
		int j;
		int vals [SLOT_COUNT];
		k_use = (keep_thr < EIGHT_SLOT_LIMIT) ? SLOT_COUNT : SLOTS_NARROW;
		pos = seen_count + 1;
		res = '0;
		if (pos <= MAX_VALUES && v > keep_thr && kept_count < k_use) begin
			slot_val[kept_count] = v;
			slot_pos[kept_count] = pos[POS_W-1:0];
			kept_count++;
		end
		seen_count = (pos > MAX_VALUES) ? MAX_VALUES : pos;
		if (!last)
			return 1'b0;
		if (slot_val[0] > 0) begin
			maxv = int'(slot_val[0]);
			res.found = 1'b1;
			res.best_index = slot_pos[0];
			for (int i = 1; i < k_use; i++) begin
				if (slot_val[i] > maxv) begin
					maxv = int'(slot_val[i]);
					res.best_index = slot_pos[i];
				end
			end
			for (int i = 0; i < k_use; i++)
				vals[i] = int'(slot_val[i]);
			for (int i = 1; i < k_use; i++) begin
				t = vals[i];
				j = i;
				while (j > 0 && vals[j-1] < t) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = t;
			end
			score = 0;
			for (int i = 0; i < k_use; i++)
				score += (k_use - i) * vals[i];
			res.pixel_score = score[SCORE_W-1:0];
			res.good = (score >= good_thr);
		end
		clear_pixel_slots();
		return 1'b1;
	endfunction

	// side 0: sample gaps, side 1: result stalls
	function automatic int draw_wait(input int side);
		if (stretch_left[side] == 0) begin
			quiet[side] = ($urandom_range(0, 2) == 0);
			stretch_left[side] = $urandom_range(10, 60);
		end
		stretch_left[side]--;
		if (quiet[side] || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(negedge clk) begin : sample_drive
		sample_item_t next_item;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else if (!sample_bus.valid || sample_xfer) begin
			if (send_gap != 0) begin
				sample_bus.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sample_queue.size() != 0) begin
				next_item = sample_queue.pop_front();
				sample_bus.valid <= 1'b1;
				sample_bus.sample_value <= next_item.value;
				sample_bus.last_of_pixel <= next_item.last;
				send_gap <= draw_wait(0);
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_ready_drive
		int hold_n;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (result_xfer) begin
			hold_n = draw_wait(1);
			result_bus.ready <= (hold_n == 0);
			ready_hold <= (hold_n == 0) ? 0 : hold_n - 1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : transfer_monitor
		pixel_result_t got;
		pixel_result_t want;
		pixel_result_t fresh;
		if (arst_n) begin
			sample_xfer <= sample_bus.valid && sample_bus.ready;
			result_xfer <= result_bus.valid && result_bus.ready;
			if (result_bus.valid && result_bus.ready) begin
				got.found = result_bus.found;
				got.best_index = result_bus.best_index;
				got.pixel_score = result_bus.pixel_score;
				got.good = result_bus.good;
				if (pending_scores.size() == 0) begin
					report_mismatch("result transfer with no pixel outstanding");
				end else begin
					want = pending_scores.pop_front();
					if (got.found !== want.found)
						report_mismatch($sformatf("found %0b, want %0b", got.found,
							want.found));
					if (got.best_index !== want.best_index)
						report_mismatch($sformatf("best_index %0d, want %0d",
							got.best_index, want.best_index));
					if (got.pixel_score !== want.pixel_score)
						report_mismatch($sformatf("pixel_score %0d, want %0d",
							$signed(got.pixel_score), $signed(want.pixel_score)));
					if (got.good !== want.good)
						report_mismatch($sformatf("good %0b, want %0b", got.good,
							want.good));
				end
			end
			if (sample_bus.valid && sample_bus.ready) begin
				if (rank_pixel_sample(sample_bus.sample_value, sample_bus.last_of_pixel,
					fresh))
					pending_scores.push_back(fresh);
			end
			if ((sample_bus.valid && sample_bus.ready) ||
				(result_bus.valid && result_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SAMPLE_THRESHOLD: keep_thr = data[VALUE_W-1:0];
			REG_SCORE_THRESHOLD: good_thr = data[SCORE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int keep, input int good_at);
		logic [5:0] junk;
		junk = 6'($urandom_range(0, 63));
		write_reg(REG_SAMPLE_THRESHOLD, {junk, keep[VALUE_W-1:0]});
		write_reg(REG_SCORE_THRESHOLD, good_at[SCORE_W-1:0]);
	endtask

	// drain both channels, then let the pipeline settle
	task automatic wait_idle();
		while (sample_queue.size() != 0 || sample_bus.valid || pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_sample(input int v, input bit last);
		sample_item_t it;
		it.value = v[VALUE_W-1:0];
		it.last = last;
		sample_queue.push_back(it);
		queued_total++;
	endtask

	function automatic int pick_value();
		int thr;
		thr = int'(keep_thr);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 2))
					0: return 32767;
					1: return -32768;
					default: return thr;
				endcase
			end
			1, 2: return int'($urandom_range(0, 65535)) - 32768;
			3: return thr - int'($urandom_range(0, thr + 32768));
			default: begin
				if (thr >= 32767)
					return int'($urandom_range(0, 65535)) - 32768;
				return thr + 1 + int'($urandom_range(0, 32766 - thr));
			end
		endcase
	endfunction

	task automatic add_random_pixel(input bit close);
		int len;
		case ($urandom_range(0, 9))
			7, 8: len = $urandom_range(7, 12);
			9: len = $urandom_range(13, 40);
			default: len = $urandom_range(1, 6);
		endcase
		for (int i = 1; i <= len; i++)
			add_sample(pick_value(), close && i == len);
	endtask

	initial begin : stimulus
		int start;
		int len;
		int keep;
		int good_at;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SAMPLE_THRESHOLD;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.sample_value = '0;
		sample_bus.last_of_pixel = 1'b0;
		result_bus.ready = 1'b0;
		keep_thr = SAMPLE_THRESHOLD_RESET;
		good_thr = SCORE_THRESHOLD_RESET;
		clear_pixel_slots();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// four slots at reset threshold; tie on the maximum keeps the earliest
		add_sample(32767, 1);
		add_sample(-32768, 1);
		add_sample(6554, 0);
		add_sample(20000, 0);
		add_sample(8000, 0);
		add_sample(20000, 0);
		add_sample(6555, 0);
		add_sample(32767, 1);
		wait_idle();

		set_config(-32768, SCORE_MAX);
		add_sample(0, 1);
		for (int i = 1; i <= SLOT_COUNT; i++)
			add_sample(32767, i == SLOT_COUNT);
		add_sample(100, 0);
		add_sample(-32767, 0);
		add_sample(5, 1);
		wait_idle();

		set_config(32767, SCORE_MIN);
		add_sample(32767, 1);
		wait_idle();

		// switch from eight slots to four partway through a pixel
		set_config(-100, 0);
		for (int i = 1; i <= 6; i++)
			add_sample(40 + 10 * i, 0);
		wait_idle();
		set_config(20000, 0);
		add_sample(30000, 1);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 7))
				0: keep = -32768;
				1: keep = 32767;
				2: keep = 6553;
				3: keep = 6554;
				4, 5: keep = int'($urandom_range(0, 22000)) - 2000;
				default: keep = int'($urandom_range(0, 65535)) - 32768;
			endcase
			case ($urandom_range(0, 5))
				0: good_at = SCORE_MIN;
				1: good_at = SCORE_MAX;
				default: good_at = int'($urandom_range(0, 450000)) - 50000;
			endcase
			if (phase == 2)
				keep = 10000;
			set_config(keep, good_at);
			if (phase == 2) begin
				// overlong pixel: only samples up to the position limit may be kept
				len = MAX_VALUES + 1 + $urandom_range(0, 40);
				for (int i = 1; i <= len; i++) begin
					if (i >= MAX_VALUES - 1 && i <= MAX_VALUES + 4)
						add_sample(10001 + int'($urandom_range(0, 22766)), i == len);
					else
						add_sample(10000 - int'($urandom_range(0, 42768)), i == len);
				end
			end
			start = queued_total;
			while (queued_total - start < PHASE_ITEMS)
				add_random_pixel(1'b1);
			if (phase != 1 && $urandom_range(0, 1) == 1)
				add_random_pixel(1'b0);
			wait_idle();
		end
		add_sample(pick_value(), 1);
		wait_idle();

		if (mismatch_count == 0 && pending_scores.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
